// ===== rtl/core/fisheye_point_distort_assert.svh =====
// Assertion macros for the fisheye point distortion core.
// Used by the top level only; expects signals clk and rst_n in scope.
`ifndef FISHEYE_POINT_DISTORT_ASSERT_SVH
`define FISHEYE_POINT_DISTORT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FPD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fisheye_point_distort: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fisheye_point_distort: next-cycle check failed");

`endif

// ===== rtl/core/fpd_pkg.sv =====
// Shared types and constants of the fisheye point distortion core.
// No dependencies; imported by every module of the core.
`timescale 1ns / 1ps

package fpd_pkg;

  // Magnitude width of a coordinate and width of the radius.
  localparam int MAG_W        = 32;
  localparam int RAD_W        = 32;
  // Angle in Q30, never negative after the clamp.
  localparam int THETA_W      = 31;
  // Iteration counts of the pipelined units.
  localparam int ISQRT_STEPS  = 32;
  localparam int CORDIC_STEPS = 30;
  // Distorted angle (Q24) and quotient widths.
  localparam int TD_W         = 40;
  localparam int QUO_W        = 56;
  // Configuration port widths.
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;
  localparam int THR_W        = 24;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_K1  = 3'd0,
    CFG_K2  = 3'd1,
    CFG_K3  = 3'd2,
    CFG_K4  = 3'd3,
    CFG_THR = 3'd4
  } cfg_idx_t;

  // Distortion coefficients, signed Q8.24.
  typedef struct packed {
    logic signed [31:0] k1;
    logic signed [31:0] k2;
    logic signed [31:0] k3;
    logic signed [31:0] k4;
  } coef_t;

  // Rounded atan(2^-i) in Q30.
  localparam logic [31:0] ATAN_TAB [0:CORDIC_STEPS-1] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
    32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536,
    32'd32768, 32'd16384, 32'd8192, 32'd4096, 32'd2048,
    32'd1024, 32'd512, 32'd256, 32'd128, 32'd64,
    32'd32, 32'd16, 32'd8, 32'd4, 32'd2
  };

endpackage

// ===== rtl/core/fpd_ifs.sv =====
// Valid/ready channel interfaces of the fisheye point distortion core.
// Depends on fpd_pkg for the configuration port widths.
`timescale 1ns / 1ps

interface fpd_in_if #(parameter int CW = 24);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] u_in;
  logic signed [CW-1:0] v_in;
  modport source (output valid, output u_in, output v_in, input ready);
  modport sink   (input valid, input u_in, input v_in, output ready);
endinterface

interface fpd_out_if #(parameter int CW = 24);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] u_out;
  logic signed [CW-1:0] v_out;
  logic                 passed_through;
  logic                 saturated;
  modport source (output valid, output u_out, output v_out, output passed_through,
                  output saturated, input ready);
  modport sink   (input valid, input u_out, input v_out, input passed_through,
                  input saturated, output ready);
endinterface

interface fpd_cfg_if import fpd_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/fpd_isqrt.sv =====
// Squared radius and pipelined integer square root, one result bit per stage.
// Depends on fpd_pkg.
`timescale 1ns / 1ps

module fpd_isqrt import fpd_pkg::*; #(
  parameter int CW   = 24,
  parameter int SB_W = 48
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [CW-1:0] u,
  input  logic signed [CW-1:0] v,
  input  logic [SB_W-1:0]      in_sb,
  output logic                 out_valid,
  output logic [RAD_W-1:0]     r,
  output logic [SB_W-1:0]      out_sb
);

  localparam int LAST = ISQRT_STEPS + 1;

  logic [MAG_W:0]   u_ext, v_ext, u_neg, v_neg;
  logic [MAG_W-1:0] u_mag, v_mag;
  logic [63:0]      squ_r, sqv_r;
  logic [63:0]      n_r   [1:LAST];
  logic [63:0]      res_r [1:LAST];
  logic [SB_W-1:0]  sb_r  [0:LAST];
  logic             vld_r [0:LAST];

  // Coordinate magnitudes.
  assign u_ext = {{(MAG_W + 1 - CW){u[CW-1]}}, u};
  assign v_ext = {{(MAG_W + 1 - CW){v[CW-1]}}, v};
  assign u_neg = (MAG_W + 1)'(0) - u_ext;
  assign v_neg = (MAG_W + 1)'(0) - v_ext;
  assign u_mag = u[CW-1] ? u_neg[MAG_W-1:0] : u_ext[MAG_W-1:0];
  assign v_mag = v[CW-1] ? v_neg[MAG_W-1:0] : v_ext[MAG_W-1:0];

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= LAST; s++) vld_r[s] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int s = 1; s <= LAST; s++) vld_r[s] <= vld_r[s-1];
    end
  end

  // Squares, then their sum as the root operand.
  always_ff @(posedge clk) begin
    if (en) begin
      squ_r    <= 64'(u_mag) * 64'(u_mag);
      sqv_r    <= 64'(v_mag) * 64'(v_mag);
      sb_r[0]  <= in_sb;
      n_r[1]   <= squ_r + sqv_r;
      res_r[1] <= '0;
      sb_r[1]  <= sb_r[0];
    end
  end

  // One digit-by-digit step per stage.
  for (genvar k = 0; k < ISQRT_STEPS; k++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;
    assign trial = res_r[k+1] + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        sb_r[k+2] <= sb_r[k+1];
        if (n_r[k+1] >= trial) begin
          n_r[k+2]   <= n_r[k+1] - trial;
          res_r[k+2] <= (res_r[k+1] >> 1) + BIT;
        end else begin
          n_r[k+2]   <= n_r[k+1];
          res_r[k+2] <= res_r[k+1] >> 1;
        end
      end
    end
  end

  assign out_valid = vld_r[LAST];
  assign r         = res_r[LAST][RAD_W-1:0];
  assign out_sb    = sb_r[LAST];

endmodule

// ===== rtl/core/fpd_atan.sv =====
// Pipelined CORDIC vectoring unit: theta = atan(r) in Q30, one iteration per stage.
// Depends on fpd_pkg for the angle table.
`timescale 1ns / 1ps

module fpd_atan import fpd_pkg::*; #(
  parameter int SB_W = 48
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic [RAD_W-1:0]   r,
  input  logic [SB_W-1:0]    in_sb,
  output logic               out_valid,
  output logic [THETA_W-1:0] theta,
  output logic [SB_W-1:0]    out_sb
);

  localparam int XW = 50;
  localparam int ZW = 33;

  logic signed [XW-1:0] x_r  [0:CORDIC_STEPS];
  logic signed [XW-1:0] y_r  [0:CORDIC_STEPS];
  logic signed [ZW-1:0] z_r  [0:CORDIC_STEPS];
  logic [SB_W-1:0]      sb_r [0:CORDIC_STEPS];
  logic                 vld_r[0:CORDIC_STEPS];

  // Start vector (1, r) with the radius moved to Q30.
  assign x_r[0]   = XW'(64'd1 << 30);
  assign y_r[0]   = $signed({{(XW - RAD_W - 14){1'b0}}, r, 14'd0});
  assign z_r[0]   = '0;
  assign sb_r[0]  = in_sb;
  assign vld_r[0] = in_valid;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
    logic signed [XW-1:0] xs, ys;
    logic signed [ZW-1:0] ang;
    assign xs  = x_r[i] >>> i;
    assign ys  = y_r[i] >>> i;
    assign ang = $signed({1'b0, ATAN_TAB[i]});

    // Valid bit of this stage.
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (en) begin
        vld_r[i+1] <= vld_r[i];
      end
    end

    // Rotate toward the x axis.
    always_ff @(posedge clk) begin
      if (en) begin
        sb_r[i+1] <= sb_r[i];
        if (!y_r[i][XW-1]) begin
          x_r[i+1] <= x_r[i] + ys;
          y_r[i+1] <= y_r[i] - xs;
          z_r[i+1] <= z_r[i] + ang;
        end else begin
          x_r[i+1] <= x_r[i] - ys;
          y_r[i+1] <= y_r[i] + xs;
          z_r[i+1] <= z_r[i] - ang;
        end
      end
    end
  end

  // A negative angle clamps to zero.
  assign theta     = z_r[CORDIC_STEPS][ZW-1] ? '0 : z_r[CORDIC_STEPS][THETA_W-1:0];
  assign out_valid = vld_r[CORDIC_STEPS];
  assign out_sb    = sb_r[CORDIC_STEPS];

endmodule

// ===== rtl/core/fpd_poly.sv =====
// Distortion polynomial: powers of theta, coefficient sum and distorted angle.
// Depends on fpd_pkg; eight register stages, with multipliers in five of them.
`timescale 1ns / 1ps

module fpd_poly import fpd_pkg::*; #(
  parameter int SB_W = 48
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  coef_t              coef,
  input  logic               in_valid,
  input  logic [THETA_W-1:0] theta,
  input  logic [SB_W-1:0]    in_sb,
  output logic               out_valid,
  output logic [TD_W-1:0]    td,
  output logic               neg,
  output logic [SB_W-1:0]    out_sb
);

  localparam int NST = 8;
  localparam logic [63:0] S_ONE = 64'd1 << 48;

  logic                 vld_r [1:NST];
  logic [SB_W-1:0]      sb_r  [1:NST];
  logic [THETA_W-1:0]   th_r  [1:6];
  logic [61:0]          sq_r;
  logic [51:0]          t4p_r;
  logic [53:0]          t6p_r;
  logic [55:0]          t8p_r;
  logic [25:0]          t2_2_r, t2_3_r;
  logic [27:0]          t4_3_r;
  logic [63:0]          m1_r, m2_r, m3_r, m4_r, a_r, b_r, d_r;
  logic signed [39:0]   p_r;
  logic [TD_W-1:0]      td_r;
  logic                 neg_r;

  logic [25:0]          t2;
  logic [27:0]          t4;
  logic [29:0]          t6;
  logic [31:0]          t8;
  logic signed [65:0]   m1_nxt, m2_nxt, m3_nxt, m4_nxt, d_nxt;
  logic [63:0]          s_nxt, dmag_nxt;

  assign t2 = sq_r[61:36];
  assign t4 = t4p_r[51:24];
  assign t6 = t6p_r[53:24];
  assign t8 = t8p_r[55:24];

  // Coefficient products and the distorted angle wrap to 64 bits.
  assign m1_nxt   = coef.k1 * $signed({1'b0, t2_3_r});
  assign m2_nxt   = coef.k2 * $signed({1'b0, t4_3_r});
  assign m3_nxt   = coef.k3 * $signed({1'b0, t6});
  assign m4_nxt   = coef.k4 * $signed({1'b0, t8});
  assign s_nxt    = a_r + b_r + S_ONE;
  assign d_nxt    = $signed({1'b0, th_r[6][THETA_W-1:6]}) * p_r;
  assign dmag_nxt = d_r[63] ? 64'd0 - d_r : d_r;

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 1; s <= NST; s++) vld_r[s] <= 1'b0;
    end else if (en) begin
      vld_r[1] <= in_valid;
      for (int s = 2; s <= NST; s++) vld_r[s] <= vld_r[s-1];
    end
  end

  // Datapath stages.
  always_ff @(posedge clk) begin
    if (en) begin
      sb_r[1] <= in_sb;
      for (int s = 2; s <= NST; s++) sb_r[s] <= sb_r[s-1];
      th_r[1] <= theta;
      for (int s = 2; s <= 6; s++) th_r[s] <= th_r[s-1];
      // Theta squared.
      sq_r    <= 62'(theta) * 62'(theta);
      // Fourth power.
      t4p_r   <= 52'(t2) * 52'(t2);
      t2_2_r  <= t2;
      // Sixth and eighth powers.
      t6p_r   <= 54'(t4) * 54'(t2_2_r);
      t8p_r   <= 56'(t4) * 56'(t4);
      t2_3_r  <= t2_2_r;
      t4_3_r  <= t4;
      // Coefficient products.
      m1_r    <= m1_nxt[63:0];
      m2_r    <= m2_nxt[63:0];
      m3_r    <= m3_nxt[63:0];
      m4_r    <= m4_nxt[63:0];
      // Pairwise sums, then the Q24 factor.
      a_r     <= m1_r + m2_r;
      b_r     <= m3_r + m4_r;
      p_r     <= $signed(s_nxt[63:24]);
      // Distorted angle, then its magnitude and sign.
      d_r     <= d_nxt[63:0];
      td_r    <= dmag_nxt[63:24];
      neg_r   <= d_r[63];
    end
  end

  assign out_valid = vld_r[NST];
  assign out_sb    = sb_r[NST];
  assign td        = td_r;
  assign neg       = neg_r;

endmodule

// ===== rtl/core/fpd_div.sv =====
// Pipelined restoring divider: scale = (td << 16) / r, one quotient bit per stage.
// Depends on fpd_pkg.
`timescale 1ns / 1ps

module fpd_div import fpd_pkg::*; #(
  parameter int SB_W = 48
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [TD_W-1:0]  td,
  input  logic [RAD_W-1:0] r,
  input  logic [SB_W-1:0]  in_sb,
  output logic             out_valid,
  output logic [QUO_W-1:0] quo,
  output logic [SB_W-1:0]  out_sb
);

  logic [RAD_W-1:0] rem_r [0:QUO_W];
  logic [QUO_W-1:0] nq_r  [0:QUO_W];
  logic [RAD_W-1:0] den_r [0:QUO_W];
  logic [SB_W-1:0]  sb_r  [0:QUO_W];
  logic             vld_r [0:QUO_W];

  // Dividend bits shift out of nq while quotient bits shift in.
  assign rem_r[0] = '0;
  assign nq_r[0]  = {td, 16'd0};
  assign den_r[0] = r;
  assign sb_r[0]  = in_sb;
  assign vld_r[0] = in_valid;

  for (genvar j = 0; j < QUO_W; j++) begin : g_bit
    logic [RAD_W:0] trial, diff;
    logic           ge;
    assign trial = {rem_r[j], nq_r[j][QUO_W-1]};
    assign diff  = trial - {1'b0, den_r[j]};
    assign ge    = trial >= {1'b0, den_r[j]};

    // Valid bit of this stage.
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j+1] <= 1'b0;
      end else if (en) begin
        vld_r[j+1] <= vld_r[j];
      end
    end

    // Compare, subtract and shift.
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j+1] <= ge ? diff[RAD_W-1:0] : trial[RAD_W-1:0];
        nq_r[j+1]  <= {nq_r[j][QUO_W-2:0], ge};
        den_r[j+1] <= den_r[j];
        sb_r[j+1]  <= sb_r[j];
      end
    end
  end

  assign out_valid = vld_r[QUO_W];
  assign quo       = nq_r[QUO_W];
  assign out_sb    = sb_r[QUO_W];

endmodule

// ===== rtl/core/fpd_scale.sv =====
// Coordinate scaling with rounding, saturation and pass-through selection.
// Depends on fpd_pkg; the last stage is the output register of the core.
`timescale 1ns / 1ps

module fpd_scale import fpd_pkg::*; #(
  parameter int CW = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [QUO_W-1:0]     quo,
  input  logic                 neg,
  input  logic signed [CW-1:0] u,
  input  logic signed [CW-1:0] v,
  input  logic                 pass,
  input  logic                 zero,
  output logic                 out_valid,
  output logic signed [CW-1:0] u_out,
  output logic signed [CW-1:0] v_out,
  output logic                 passed_through,
  output logic                 saturated
);

  localparam int HALF = QUO_W / 2;
  localparam logic [39:0] MAXQ = 40'((64'd1 << (CW - 1)) - 64'd1);
  localparam logic [39:0] MINQ = MAXQ + 40'd1;
  localparam logic [63:0] RND  = 64'd1 << 23;

  logic                 vld1_r, vld2_r, vld3_r;
  logic [59:0]          ulo_r, uhi_r, vlo_r, vhi_r;
  logic                 usg1_r, vsg1_r, usg2_r, vsg2_r;
  logic signed [CW-1:0] u1_r, v1_r, u2_r, v2_r;
  logic                 pass1_r, pass2_r, zero1_r, zero2_r;
  logic [39:0]          uq_r, vq_r;
  logic signed [CW-1:0] uo_r, vo_r;
  logic                 pt_r, sat_r;

  logic [MAG_W:0]       u_ext, v_ext, u_neg, v_neg;
  logic [MAG_W-1:0]     u_mag, v_mag;
  logic [63:0]          usum, vsum;
  logic [CW:0]          uc, vc;

  // Round-to-nearest quotient, clamped to the coordinate range; MSB is the clamp flag.
  function automatic logic [CW:0] clamp_q(input logic [39:0] q, input logic ng);
    logic [39:0] nq;
    logic [CW:0] res;
    nq = 40'd0 - q;
    if (ng) begin
      if (q > MINQ) res = {1'b1, 1'b1, {(CW - 1){1'b0}}};
      else          res = {1'b0, nq[CW-1:0]};
    end else begin
      if (q > MAXQ) res = {1'b1, MAXQ[CW-1:0]};
      else          res = {1'b0, q[CW-1:0]};
    end
    return res;
  endfunction

  assign u_ext = {{(MAG_W + 1 - CW){u[CW-1]}}, u};
  assign v_ext = {{(MAG_W + 1 - CW){v[CW-1]}}, v};
  assign u_neg = (MAG_W + 1)'(0) - u_ext;
  assign v_neg = (MAG_W + 1)'(0) - v_ext;
  assign u_mag = u[CW-1] ? u_neg[MAG_W-1:0] : u_ext[MAG_W-1:0];
  assign v_mag = v[CW-1] ? v_neg[MAG_W-1:0] : v_ext[MAG_W-1:0];

  // Product of magnitude and scale, wrapped to 64 bits, plus rounding.
  assign usum = 64'(ulo_r) + (64'(uhi_r) << HALF) + RND;
  assign vsum = 64'(vlo_r) + (64'(vhi_r) << HALF) + RND;
  assign uc   = clamp_q(uq_r, usg2_r);
  assign vc   = clamp_q(vq_r, vsg2_r);

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_valid;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Partial products of the low and high scale halves.
      ulo_r   <= 60'(u_mag) * 60'(quo[HALF-1:0]);
      uhi_r   <= 60'(u_mag) * 60'(quo[QUO_W-1:HALF]);
      vlo_r   <= 60'(v_mag) * 60'(quo[HALF-1:0]);
      vhi_r   <= 60'(v_mag) * 60'(quo[QUO_W-1:HALF]);
      usg1_r  <= u[CW-1] ^ neg;
      vsg1_r  <= v[CW-1] ^ neg;
      u1_r    <= u;
      v1_r    <= v;
      pass1_r <= pass;
      zero1_r <= zero;
      // Sum and drop the fraction.
      uq_r    <= usum[63:24];
      vq_r    <= vsum[63:24];
      usg2_r  <= usg1_r;
      vsg2_r  <= vsg1_r;
      u2_r    <= u1_r;
      v2_r    <= v1_r;
      pass2_r <= pass1_r;
      zero2_r <= zero1_r;
      // Output register: pass-through, origin or scaled point.
      if (pass2_r) begin
        uo_r  <= u2_r;
        vo_r  <= v2_r;
        pt_r  <= 1'b1;
        sat_r <= 1'b0;
      end else if (zero2_r) begin
        uo_r  <= '0;
        vo_r  <= '0;
        pt_r  <= 1'b0;
        sat_r <= 1'b0;
      end else begin
        uo_r  <= $signed(uc[CW-1:0]);
        vo_r  <= $signed(vc[CW-1:0]);
        pt_r  <= 1'b0;
        sat_r <= uc[CW] | vc[CW];
      end
    end
  end

  assign out_valid      = vld3_r;
  assign u_out          = uo_r;
  assign v_out          = vo_r;
  assign passed_through = pt_r;
  assign saturated      = sat_r;

endmodule

// ===== rtl/core/fisheye_point_distort.sv =====
// Top level of the equidistant fisheye point distortion core.
// Depends on fpd_pkg, fpd_ifs, fpd_isqrt, fpd_atan, fpd_poly, fpd_div, fpd_scale.
//
//  Channel | Dir | Payload                                   | Handshake
//  in_if   | in  | u_in, v_in (signed Q8.16)                 | valid / ready
//  out_if  | out | u_out, v_out, passed_through, saturated   | valid / ready
//  cfg_if  | in  | index, data (coefficients, threshold)     | valid / ready
//
// One point per clock while not stalled; the pipeline holds the square root stages, 30 CORDIC
// iterations, 8 polynomial stages, 56 divider stages and 3 scaling stages.
// The whole pipeline advances together; it freezes only while a result waits in
// the output register and out_if.ready is low, so no request is lost or repeated.
// Reset (rst_n low, synchronous) clears the valid bits and loads the register
// defaults: coefficients zero, radius threshold one. cfg_if.ready is always high.
`timescale 1ns / 1ps

module fisheye_point_distort import fpd_pkg::*; #(
  parameter int COORD_WIDTH = 24
) (
  input  logic       clk,
  input  logic       rst_n,
  fpd_in_if.sink     in_if,
  fpd_out_if.source  out_if,
  fpd_cfg_if.sink    cfg_if
);

  localparam int CW = COORD_WIDTH;

  typedef struct packed {
    logic signed [CW-1:0] v;
    logic signed [CW-1:0] u;
  } side_a_t;

  typedef struct packed {
    logic                 zero;
    logic                 pass;
    logic [RAD_W-1:0]     rad;
    logic signed [CW-1:0] v;
    logic signed [CW-1:0] u;
  } side_b_t;

  typedef struct packed {
    logic                 neg;
    logic                 zero;
    logic                 pass;
    logic signed [CW-1:0] v;
    logic signed [CW-1:0] u;
  } side_c_t;

  localparam logic signed [CW-1:0] OUT_MAX = {1'b0, {(CW - 1){1'b1}}};
  localparam logic signed [CW-1:0] OUT_MIN = {1'b1, {(CW - 1){1'b0}}};

  coef_t              coef_r;
  logic [THR_W-1:0]   thr_r;
  logic               en;

  side_a_t            sa_in, sa_out;
  side_b_t            sb_in, sb_atan, sb_poly;
  side_c_t            sc_in, sc_out;
  logic               sq_vld, at_vld, po_vld, dv_vld;
  logic [RAD_W-1:0]   rad;
  logic [THETA_W-1:0] theta;
  logic [TD_W-1:0]    td;
  logic               neg;
  logic [QUO_W-1:0]   quo;

  // Configuration registers; unknown indexes are ignored.
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
      thr_r  <= THR_W'(1);
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        CFG_K1:  coef_r.k1 <= $signed(cfg_if.data);
        CFG_K2:  coef_r.k2 <= $signed(cfg_if.data);
        CFG_K3:  coef_r.k3 <= $signed(cfg_if.data);
        CFG_K4:  coef_r.k4 <= $signed(cfg_if.data);
        CFG_THR: thr_r     <= cfg_if.data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Global advance: stall only when the output register is full and not taken.
  assign en          = !out_if.valid || out_if.ready;
  assign in_if.ready = en;

  assign sa_in.u = in_if.u_in;
  assign sa_in.v = in_if.v_in;

  fpd_isqrt #(.CW(CW), .SB_W($bits(side_a_t))) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_if.valid),
    .u         (in_if.u_in),
    .v         (in_if.v_in),
    .in_sb     (sa_in),
    .out_valid (sq_vld),
    .r         (rad),
    .out_sb    (sa_out)
  );

  // Radius classification: below threshold, or the origin.
  assign sb_in.zero = (rad == '0);
  assign sb_in.pass = rad < RAD_W'(thr_r);
  assign sb_in.rad  = rad;
  assign sb_in.v    = sa_out.v;
  assign sb_in.u    = sa_out.u;

  fpd_atan #(.SB_W($bits(side_b_t))) u_atan (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_vld),
    .r         (rad),
    .in_sb     (sb_in),
    .out_valid (at_vld),
    .theta     (theta),
    .out_sb    (sb_atan)
  );

  fpd_poly #(.SB_W($bits(side_b_t))) u_poly (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .coef      (coef_r),
    .in_valid  (at_vld),
    .theta     (theta),
    .in_sb     (sb_atan),
    .out_valid (po_vld),
    .td        (td),
    .neg       (neg),
    .out_sb    (sb_poly)
  );

  assign sc_in.neg  = neg;
  assign sc_in.zero = sb_poly.zero;
  assign sc_in.pass = sb_poly.pass;
  assign sc_in.v    = sb_poly.v;
  assign sc_in.u    = sb_poly.u;

  fpd_div #(.SB_W($bits(side_c_t))) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (po_vld),
    .td        (td),
    .r         (sb_poly.rad),
    .in_sb     (sc_in),
    .out_valid (dv_vld),
    .quo       (quo),
    .out_sb    (sc_out)
  );

  fpd_scale #(.CW(CW)) u_scale (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (en),
    .in_valid       (dv_vld),
    .quo            (quo),
    .neg            (sc_out.neg),
    .u              (sc_out.u),
    .v              (sc_out.v),
    .pass           (sc_out.pass),
    .zero           (sc_out.zero),
    .out_valid      (out_if.valid),
    .u_out          (out_if.u_out),
    .v_out          (out_if.v_out),
    .passed_through (out_if.passed_through),
    .saturated      (out_if.saturated)
  );

  // Checks.
`include "fisheye_point_distort_assert.svh"

  `FPD_ASSERT_IMPL(a_pass_not_sat, out_if.valid && out_if.passed_through, !out_if.saturated)
  `FPD_ASSERT_IMPL(a_sat_at_limit, out_if.valid && out_if.saturated, (out_if.u_out == OUT_MAX) || (out_if.u_out == OUT_MIN) || (out_if.v_out == OUT_MAX) || (out_if.v_out == OUT_MIN))
  `FPD_ASSERT_NEXT(a_thr_write, cfg_if.valid && cfg_if.ready && (cfg_if.index == CFG_THR), thr_r == $past(cfg_if.data[THR_W-1:0]))

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench of the fisheye point distortion core.
// Depends on fpd_pkg, fpd_ifs and the fisheye_point_distort RTL.
`timescale 1ns / 1ps

module tb_top;
  import fpd_pkg::*;

  localparam int CW = 24;
  localparam int HOLD_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  // An index past the last register; a write to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LOW = 3'd5;

  typedef struct {
    logic signed [CW-1:0] u;
    logic signed [CW-1:0] v;
    bit                   pass;
    bit                   sat;
  } point_result_t;

  logic clk;
  logic rst_n;

  fpd_in_if  #(.CW(CW)) in_ch ();
  fpd_out_if #(.CW(CW)) out_ch ();
  fpd_cfg_if            cfg_ch ();

  fisheye_point_distort #(.COORD_WIDTH(CW)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // Register shadow used by the predictor.
  logic signed [31:0] coef [4];
  logic [THR_W-1:0]   radius_thr;

  point_result_t expected_points [$];
  int  errors;
  int  points_sent;
  int  points_checked;
  int  pass_seen;
  int  sat_seen;
  bit  in_gaps_on;
  bit  out_gaps_on;
  int  hold_request;
  int  idle_cycles;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Integer square root, floor.
  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Angle of the radius in Q30 by CORDIC vectoring.
  function automatic longint angle_q30(longint unsigned r);
    longint x;
    longint y;
    longint z;
    longint xs;
    longint ys;
    x = 64'sd1 <<< 30;
    y = longint'(r << 14);
    z = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(ATAN_TAB[i]);
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(ATAN_TAB[i]);
      end
    end
    return (z < 0) ? 64'sd0 : z;
  endfunction

  // Scale one coordinate, round, apply the sign and clamp.
  function automatic logic [CW-1:0] scale_coord(longint c, longint unsigned scale,
                                                bit neg, inout bit sat);
    longint maxv;
    longint unsigned mag;
    longint unsigned q;
    maxv = (64'sd1 <<< (CW - 1)) - 1;
    mag = (c < 0) ? longint'(-c) : longint'(c);
    q = (mag * scale + (64'd1 << 23)) >> 24;
    if ((c < 0) != neg) begin
      if (q > longint'(maxv) + 1) begin
        sat = 1'b1;
        return CW'(-maxv - 1);
      end
      return CW'(-longint'(q));
    end
    if (q > longint'(maxv)) begin
      sat = 1'b1;
      return CW'(maxv);
    end
    return CW'(q);
  endfunction

  // Expected distortion of one point under the current registers.
  function automatic point_result_t distort_point(logic signed [CW-1:0] u_pt,
                                                  logic signed [CW-1:0] v_pt);
    point_result_t res;
    longint u;
    longint v;
    longint unsigned au;
    longint unsigned av;
    longint unsigned r;
    longint theta;
    longint t2;
    longint t4;
    longint t6;
    longint t8;
    longint s;
    longint p;
    longint d;
    longint unsigned td;
    longint unsigned scale;
    bit neg;
    bit sat;
    u = longint'(u_pt);
    v = longint'(v_pt);
    au = (u < 0) ? -u : u;
    av = (v < 0) ? -v : v;
    r = root_floor(au * au + av * av);
    res.pass = 1'b0;
    res.sat = 1'b0;
    if (r < longint'(radius_thr)) begin
      res.u = u_pt;
      res.v = v_pt;
      res.pass = 1'b1;
      return res;
    end
    if (r == 0) begin
      res.u = '0;
      res.v = '0;
      return res;
    end
    theta = angle_q30(r);
    t2 = longint'((longint'(theta) * longint'(theta)) >>> 36);
    t4 = (t2 * t2) >>> 24;
    t6 = (t4 * t2) >>> 24;
    t8 = (t4 * t4) >>> 24;
    s = (64'sd1 <<< 48) + longint'(coef[0]) * t2 + longint'(coef[1]) * t4
        + longint'(coef[2]) * t6 + longint'(coef[3]) * t8;
    p = s >>> 24;
    d = (theta >>> 6) * p;
    neg = (d < 0);
    td = (neg ? longint'(-d) : longint'(d));
    td = td >> 24;
    scale = (td << 16) / r;
    sat = 1'b0;
    res.u = scale_coord(u, scale, neg, sat);
    res.v = scale_coord(v, scale, neg, sat);
    res.sat = sat;
    return res;
  endfunction

  // Send one point request, with an optional random gap before it.
  task automatic send_point(input logic signed [CW-1:0] u, input logic signed [CW-1:0] v);
    int gap;
    if (in_gaps_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 13);
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.u_in  <= u;
    in_ch.v_in  <= v;
    do @(posedge clk); while (!in_ch.ready);
    expected_points.push_back(distort_point(u, v));
    points_sent++;
  endtask

  // Lower valid and wait until every result has come back.
  task automatic drain_points();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Write one configuration register; only called while the core is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_K1:  coef[0] = data;
      CFG_K2:  coef[1] = data;
      CFG_K3:  coef[2] = data;
      CFG_K4:  coef[3] = data;
      CFG_THR: radius_thr = data[THR_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic write_coefs(input logic [31:0] k1, input logic [31:0] k2,
                             input logic [31:0] k3, input logic [31:0] k4);
    write_reg(CFG_K1, k1);
    write_reg(CFG_K2, k2);
    write_reg(CFG_K3, k3);
    write_reg(CFG_K4, k4);
  endtask

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return 32'($urandom_range(0, 1 << 23)) - 32'(1 << 22);
      2: return 32'd0;
      default: return 32'($urandom_range(0, 1 << 25)) - 32'(1 << 24);
    endcase
  endfunction

  function automatic logic signed [CW-1:0] rand_coord();
    logic signed [CW-1:0] c;
    case ($urandom_range(0, 5))
      0, 1: c = CW'($urandom);
      2: c = CW'($urandom_range(0, 1 << 17)) - CW'(1 << 16);
      3: c = CW'($urandom_range(0, 512)) - CW'(256);
      4: c = CW'($urandom_range(0, 1 << 21)) - CW'(1 << 20);
      default: c = '0;
    endcase
    return c;
  endfunction

  // Receiver: random stalls, plus a long hold-off on request.
  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        out_ch.ready <= 1'b0;
        hold_request--;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (out_gaps_on && $urandom_range(0, 9) == 0) begin
        out_ch.ready <= 1'b0;
        stall_left = $urandom_range(1, 13) - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    point_result_t exp_pt;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected result u=%0d v=%0d", $time, out_ch.u_out, out_ch.v_out);
        errors++;
      end else begin
        exp_pt = expected_points.pop_front();
        points_checked++;
        if (exp_pt.pass) pass_seen++;
        if (exp_pt.sat) sat_seen++;
        if (out_ch.u_out !== exp_pt.u) begin
          $display("%0t: u_out expected %0d actual %0d", $time, exp_pt.u, out_ch.u_out);
          errors++;
        end
        if (out_ch.v_out !== exp_pt.v) begin
          $display("%0t: v_out expected %0d actual %0d", $time, exp_pt.v, out_ch.v_out);
          errors++;
        end
        if (out_ch.passed_through !== exp_pt.pass) begin
          $display("%0t: passed_through expected %0b actual %0b", $time, exp_pt.pass,
                   out_ch.passed_through);
          errors++;
        end
        if (out_ch.saturated !== exp_pt.sat) begin
          $display("%0t: saturated expected %0b actual %0b", $time, exp_pt.sat,
                   out_ch.saturated);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer on the input, output or configuration channel.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (rst_n) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("%0t: timeout with %0d results pending", $time, expected_points.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Default registers: only the origin passes through; other points are distorted.
  task automatic test_reset_defaults();
    send_point('0, '0);
    send_point(24'sd1, 24'sd0);
    send_point(24'sd0, -24'sd1);
    send_point(24'sd65536, 24'sd0);
    send_point(-24'sd30000, 24'sd40000);
    drain_points();
  endtask

  // Threshold of zero with the origin special case, largest threshold, and a threshold of 65536.
  task automatic test_threshold_edges();
    write_reg(CFG_THR, 32'd0);
    send_point('0, '0);
    send_point(24'sd1, 24'sd1);
    drain_points();
    write_reg(CFG_THR, 32'hFF_FFFF);
    send_point(24'sh7F_FFFF, 24'sh7F_FFFF);
    send_point(24'sh40_0000, 24'sh00_0000);
    drain_points();
    write_reg(CFG_THR, 32'd65536);
    send_point(24'sd65535, 24'sd0);
    send_point(24'sd65536, 24'sd0);
    drain_points();
  endtask

  // Coordinate extremes under moderate distortion.
  task automatic test_field_extremes();
    write_reg(CFG_THR, 32'd1);
    write_coefs(32'hFF00_0000, 32'h0040_0000, 32'hFFF0_0000, 32'h0001_0000);
    send_point(24'sh7F_FFFF, 24'sh7F_FFFF);
    send_point(24'sh80_0000, 24'sh80_0000);
    send_point(24'sh80_0000, 24'sh7F_FFFF);
    send_point(24'sh00_0000, 24'sh80_0000);
    send_point(24'sh7F_FFFF, 24'sh00_0000);
    drain_points();
  endtask

  // Strongly negative factor mirrors the point through the origin.
  task automatic test_mirror();
    write_coefs(32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0);
    send_point(24'sd200000, -24'sd100000);
    send_point(-24'sd70000, 24'sd5000);
    drain_points();
  endtask

  // Large positive coefficients push results out of range.
  task automatic test_saturation();
    write_coefs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(24'sh7F_FFFF, 24'sh10_0000);
    send_point(24'sh80_0000, -24'sd3);
    send_point(24'sd2, 24'sd1);
    drain_points();
  endtask

  // Writes to unused indexes leave every register as it was.
  task automatic test_unknown_index();
    write_reg(CFG_UNUSED_IDX, 32'hFFFF_FFFF);
    write_reg(CFG_UNUSED_LOW, 32'h1234_5678);
    send_point(24'sd90000, 24'sd12345);
    drain_points();
  endtask

  // Random phases with random registers, a long receiver hold-off, and a final
  // phase without idling.
  task automatic test_random_stream();
    for (int ph = 0; ph < 9; ph++) begin
      write_coefs(rand_coef(), rand_coef(), rand_coef(), rand_coef());
      write_reg(CFG_THR, ($urandom_range(0, 3) == 0) ? 32'($urandom) & 32'hFF_FFFF
                                                     : 32'($urandom_range(0, 4096)));
      in_gaps_on = (ph != 8);
      out_gaps_on = (ph != 8);
      if (ph == 4) hold_request = HOLD_CYCLES;
      for (int n = 0; n < 100; n++) send_point(rand_coord(), rand_coord());
      drain_points();
    end
  endtask

  initial begin
    errors = 0;
    points_sent = 0;
    points_checked = 0;
    pass_seen = 0;
    sat_seen = 0;
    idle_cycles = 0;
    hold_request = 0;
    in_gaps_on = 1'b1;
    out_gaps_on = 1'b1;
    coef[0] = '0;
    coef[1] = '0;
    coef[2] = '0;
    coef[3] = '0;
    radius_thr = 24'd1;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.u_in = '0;
    in_ch.v_in = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_threshold_edges();
    test_field_extremes();
    test_mirror();
    test_saturation();
    test_unknown_index();
    test_random_stream();

    $display("Checked %0d of %0d points: %0d passed through, %0d saturated.",
             points_checked, points_sent, pass_seen, sat_seen);
    $display("Covered threshold and coordinate extremes, mirroring, clamping and stalls.");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
